[hw/rtl/lzwd_pkg.sv]
// lzwd_pkg: shared constants and types of the lzw code decoder
`timescale 1ns / 1ps

package lzwd_pkg;

   localparam int CODE_W = 12;   // width of one code word
   localparam int BYTE_W = 8;
   localparam int ROOTS  = 256;  // single-byte root codes
   localparam int LEN_W  = 7;    // string length, up to the largest max length plus one

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_CODE = 2'd1,
      ST_TOO_LONG = 2'd2
   } status_type;

   // command from the decode sequencer to the byte emitter
   typedef struct packed {
      logic              start;
      status_type        status;
      logic [LEN_W-1:0]  len;
   } emit_cmd_type;

endpackage

[hw/rtl/lzwd_if.sv]
// lzwd_if: valid/ready channels for code beats and result beats
`timescale 1ns / 1ps

interface lzwd_req_if;
   logic                        valid;
   logic                        ready;
   logic [lzwd_pkg::CODE_W-1:0] code;
   logic                        first_code;

   modport source (output valid, output code, output first_code, input ready);
   modport sink   (input valid, input code, input first_code, output ready);
endinterface

interface lzwd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lzwd_pkg::BYTE_W-1:0] data_byte;
   logic                        last_of_code;
   logic [1:0]                  status;

   modport source (output valid, output data_byte, output last_of_code, output status,
                   input ready);
   modport sink   (input valid, input data_byte, input last_of_code, input status,
                   output ready);
endinterface

[hw/rtl/lzwd_ram.sv]
// lzwd_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lzwd_emit.sv]
// lzwd_emit: decoded string from byte stack, or an error beat, into the result register
`timescale 1ns / 1ps

module lzwd_emit #(
   parameter int MAX_LEN = 64,
   localparam int SW = $clog2(MAX_LEN)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lzwd_pkg::emit_cmd_type        cmd,
   output logic                          busy,
   output logic                          stack_rd_en,
   output logic [SW-1:0]                 stack_rd_addr,
   input  logic [lzwd_pkg::BYTE_W-1:0]   stack_rd_data,
   lzwd_rsp_if.source                    rsp
);

   logic                          active_ff, active_in;
   logic                          err_ff, err_in;
   lzwd_pkg::status_type          err_status_ff, err_status_in;
   logic [lzwd_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [lzwd_pkg::LEN_W-1:0]    k_ff, k_in;
   logic                          pend_ff, pend_in;
   logic                          pend_last_ff, pend_last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lzwd_pkg::BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                          rsp_last_ff, rsp_last_in;
   lzwd_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic                          slot_free;
   logic                          issue;
   logic                          err_load;
   logic [lzwd_pkg::LEN_W-1:0]    k_next;

   // a read is only issued when the result register is free by the time data returns
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign issue     = active_ff && !err_ff && !pend_ff && slot_free && (k_ff != len_ff);
   assign err_load  = active_ff && err_ff && slot_free;
   assign k_next    = lzwd_pkg::LEN_W'(k_ff + 1'b1);

   always_comb begin
      active_in     = active_ff;
      err_in        = err_ff;
      err_status_in = err_status_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      pend_in       = issue;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.start) begin
         active_in     = 1'b1;
         err_in        = (cmd.status != lzwd_pkg::ST_OK);
         err_status_in = cmd.status;
         len_in        = cmd.len;
         k_in          = '0;
      end
      if (issue) begin
         k_in         = k_next;
         pend_last_in = (k_next == len_ff);
      end
      if (pend_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = stack_rd_data;
         rsp_last_in   = pend_last_ff;
         rsp_status_in = lzwd_pkg::ST_OK;
         if (pend_last_ff) begin
            active_in = 1'b0;
         end
      end
      if (err_load) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = '0;
         rsp_last_in   = 1'b1;
         rsp_status_in = err_status_ff;
         active_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff        <= err_in;
      err_status_ff <= err_status_in;
      len_ff        <= len_in;
      k_ff          <= k_in;
      pend_last_ff  <= pend_last_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = active_ff || cmd.start;
   assign stack_rd_en      = issue;
   assign stack_rd_addr    = k_ff[SW-1:0];
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.data_byte    = rsp_byte_ff;
   assign rsp.last_of_code = rsp_last_ff;
   assign rsp.status       = rsp_status_ff;

endmodule

[hw/rtl/lzw_code_decoder.sv]
// lzw_code_decoder: lzw decoder top level, dictionary walk sequencer and memories
// a code's bytes go out only after its whole chain is walked, one dictionary read per
// dictionary entry on it; each byte is one registered stack read, issued after the last
// read returned and while rsp has room; an error gives a single error beat, and the
// next code is taken once the emitter has loaded the previous code's last beat
// reset: synchronous; the rams are not cleared, entries are written as a stream builds them
`timescale 1ns / 1ps

module lzw_code_decoder #(
   parameter int DICT_ENTRIES = 4096,
   parameter int MAX_LEN      = 64
) (
   input  logic        clock,
   input  logic        reset,
   lzwd_req_if.sink    req_bus,
   lzwd_rsp_if.source  rsp_bus
);

   localparam int AW = $clog2(DICT_ENTRIES);
   localparam int NW = AW + 1;
   localparam int CW = (NW > lzwd_pkg::CODE_W) ? NW : lzwd_pkg::CODE_W;
   localparam int SW = $clog2(MAX_LEN);
   localparam int LW = lzwd_pkg::LEN_W;
   localparam int BW = lzwd_pkg::BYTE_W;
   localparam int DW = AW + BW + LW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_WALK,
      S_ROOT,
      S_ADD,
      S_WAIT
   } state_type;

   state_type              state_ff, state_in;
   logic [NW-1:0]          next_ff, next_in;
   logic [AW-1:0]          prev_code_ff, prev_code_in;
   logic [AW-1:0]          code_ff, code_in;
   logic [AW-1:0]          cur_ff, cur_in;
   logic [BW-1:0]          prev_first_ff, prev_first_in;
   logic [BW-1:0]          head_ff, head_in;
   logic [LW-1:0]          prev_len_ff, prev_len_in;
   logic [LW-1:0]          len_ff, len_in;
   logic [SW-1:0]          idx_ff, idx_in;
   logic                   active_ff, active_in;
   lzwd_pkg::emit_cmd_type cmd_ff, cmd_in;

   logic [CW-1:0]          code_ext;
   logic [CW-1:0]          next_ext;
   logic                   dict_full;
   logic [LW-1:0]          kw_len;
   logic [LW-1:0]          prev_last;
   logic [LW-1:0]          look_len;
   logic [LW-1:0]          look_last;
   logic [LW-1:0]          max_len;
   logic                   do_step;
   logic [SW-1:0]          step_idx;

   logic                   dict_we, dict_re;
   logic [AW-1:0]          dict_waddr, dict_raddr;
   logic [DW-1:0]          dict_wdata, dict_rdata;
   logic [AW-1:0]          ent_prefix;
   logic [BW-1:0]          ent_suffix;
   logic [LW-1:0]          ent_len;

   logic                   stack_we, stack_re;
   logic [SW-1:0]          stack_waddr, stack_raddr;
   logic [BW-1:0]          stack_wdata, stack_rdata;
   logic                   emit_busy;

   assign code_ext   = CW'(req_bus.code);
   assign next_ext   = CW'(next_ff);
   assign dict_full  = (next_ff >= NW'(DICT_ENTRIES));
   assign kw_len     = LW'(prev_len_ff + 1'b1);
   assign prev_last  = LW'(prev_len_ff - 1'b1);
   assign max_len    = LW'(MAX_LEN);
   // dictionary word: prefix code, suffix byte, string length
   assign ent_prefix = dict_rdata[DW-1 -: AW];
   assign ent_suffix = dict_rdata[LW +: BW];
   assign ent_len    = dict_rdata[LW-1:0];
   assign look_len   = (ent_len == '0) ? LW'(1) : ent_len;
   assign look_last  = LW'(look_len - 1'b1);

   always_comb begin
      state_in      = state_ff;
      next_in       = next_ff;
      prev_code_in  = prev_code_ff;
      code_in       = code_ff;
      cur_in        = cur_ff;
      prev_first_in = prev_first_ff;
      head_in       = head_ff;
      prev_len_in   = prev_len_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      active_in     = active_ff;
      cmd_in        = '{start: 1'b0, status: lzwd_pkg::ST_OK, len: '0};
      dict_we       = 1'b0;
      dict_re       = 1'b0;
      dict_waddr    = next_ff[AW-1:0];
      dict_raddr    = ent_prefix;
      dict_wdata    = {prev_code_ff, head_ff, kw_len};
      stack_we      = 1'b0;
      stack_waddr   = idx_ff;
      stack_wdata   = cur_ff[BW-1:0];
      do_step       = 1'b0;
      step_idx      = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               code_in = code_ext[AW-1:0];
               if (req_bus.first_code) begin
                  next_in = NW'(lzwd_pkg::ROOTS);
                  if (code_ext >= CW'(lzwd_pkg::ROOTS)) begin
                     active_in = 1'b0;
                     cmd_in    = '{start: 1'b1, status: lzwd_pkg::ST_BAD_CODE, len: '0};
                  end else begin
                     stack_we      = 1'b1;
                     stack_waddr   = '0;
                     stack_wdata   = req_bus.code[BW-1:0];
                     prev_code_in  = code_ext[AW-1:0];
                     prev_first_in = req_bus.code[BW-1:0];
                     prev_len_in   = LW'(1);
                     active_in     = 1'b1;
                     cmd_in        = '{start: 1'b1, status: lzwd_pkg::ST_OK, len: LW'(1)};
                  end
                  state_in = S_WAIT;
               end else if (!active_ff) begin
                  state_in = S_IDLE;
               end else if (code_ext < next_ext) begin
                  if (code_ext < CW'(lzwd_pkg::ROOTS)) begin
                     stack_we    = 1'b1;
                     stack_waddr = '0;
                     stack_wdata = req_bus.code[BW-1:0];
                     head_in     = req_bus.code[BW-1:0];
                     len_in      = LW'(1);
                     state_in    = S_ADD;
                  end else begin
                     dict_re    = 1'b1;
                     dict_raddr = code_ext[AW-1:0];
                     state_in   = S_LOOK;
                  end
               end else if ((code_ext == next_ext) && !dict_full) begin
                  // code not yet in the table: previous string plus its own first byte
                  if (kw_len > max_len) begin
                     active_in = 1'b0;
                     cmd_in    = '{start: 1'b1, status: lzwd_pkg::ST_TOO_LONG, len: '0};
                     state_in  = S_WAIT;
                  end else begin
                     stack_we    = 1'b1;
                     stack_waddr = prev_len_ff[SW-1:0];
                     stack_wdata = prev_first_ff;
                     len_in      = kw_len;
                     idx_in      = prev_last[SW-1:0];
                     cur_in      = prev_code_ff;
                     if (prev_code_ff < AW'(lzwd_pkg::ROOTS)) begin
                        state_in = S_ROOT;
                     end else begin
                        dict_re    = 1'b1;
                        dict_raddr = prev_code_ff;
                        state_in   = S_WALK;
                     end
                  end
               end else begin
                  active_in = 1'b0;
                  cmd_in    = '{start: 1'b1, status: lzwd_pkg::ST_BAD_CODE, len: '0};
                  state_in  = S_WAIT;
               end
            end
         end
         S_LOOK: begin
            if (ent_len > max_len) begin
               active_in = 1'b0;
               cmd_in    = '{start: 1'b1, status: lzwd_pkg::ST_TOO_LONG, len: '0};
               state_in  = S_WAIT;
            end else begin
               len_in   = look_len;
               step_idx = look_last[SW-1:0];
               do_step  = 1'b1;
            end
         end
         S_WALK: begin
            do_step = 1'b1;
         end
         S_ROOT: begin
            stack_we = 1'b1;
            head_in  = cur_ff[BW-1:0];
            state_in = S_ADD;
         end
         S_ADD: begin
            if (!dict_full) begin
               dict_we = 1'b1;
               next_in = NW'(next_ff + 1'b1);
            end
            prev_code_in  = code_ff;
            prev_first_in = head_ff;
            prev_len_in   = len_ff;
            cmd_in        = '{start: 1'b1, status: lzwd_pkg::ST_OK, len: len_ff};
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (!emit_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // one link of the prefix chain: suffix goes on the stack, non-root prefix is read next
      if (do_step) begin
         stack_we    = 1'b1;
         stack_waddr = step_idx;
         stack_wdata = ent_suffix;
         if (step_idx == '0) begin
            head_in  = ent_suffix;
            state_in = S_ADD;
         end else begin
            idx_in = SW'(step_idx - 1'b1);
            cur_in = ent_prefix;
            if (ent_prefix < AW'(lzwd_pkg::ROOTS)) begin
               state_in = S_ROOT;
            end else begin
               dict_re    = 1'b1;
               dict_raddr = ent_prefix;
               state_in   = S_WALK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_ff       <= NW'(lzwd_pkg::ROOTS);
         prev_code_ff  <= '0;
         prev_first_ff <= '0;
         active_ff     <= 1'b0;
         cmd_ff        <= '{start: 1'b0, status: lzwd_pkg::ST_OK, len: '0};
      end else begin
         state_ff      <= state_in;
         next_ff       <= next_in;
         prev_code_ff  <= prev_code_in;
         prev_first_ff <= prev_first_in;
         active_ff     <= active_in;
         cmd_ff        <= cmd_in;
      end
      code_ff     <= code_in;
      cur_ff      <= cur_in;
      head_ff     <= head_in;
      prev_len_ff <= prev_len_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
   end

   assign req_bus.ready = (state_ff == S_IDLE);

   lzwd_ram #(
      .WIDTH (DW),
      .DEPTH (DICT_ENTRIES)
   ) u_dict_ram (
      .clock   (clock),
      .wr_en   (dict_we),
      .wr_addr (dict_waddr),
      .wr_data (dict_wdata),
      .rd_en   (dict_re),
      .rd_addr (dict_raddr),
      .rd_data (dict_rdata)
   );

   lzwd_ram #(
      .WIDTH (BW),
      .DEPTH (MAX_LEN)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_en   (stack_re),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   lzwd_emit #(
      .MAX_LEN (MAX_LEN)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd_ff),
      .busy          (emit_busy),
      .stack_rd_en   (stack_re),
      .stack_rd_addr (stack_raddr),
      .stack_rd_data (stack_rdata),
      .rsp           (rsp_bus)
   );

   // next free code stays within the root count and the table size
   assert property (@(posedge clock) disable iff (reset)
      (next_ff >= NW'(lzwd_pkg::ROOTS)) && (next_ff <= NW'(DICT_ENTRIES)))
      else $error("next free code out of range");

   // a new code is only taken once the emitter has drained the previous one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !emit_busy)
      else $error("emitter busy while idle");

   // the stack is never written while it is being read out
   assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> !stack_we)
      else $error("stack written during read-out");

   // every error leaves the stream inactive
   assert property (@(posedge clock) disable iff (reset)
      (cmd_ff.start && (cmd_ff.status != lzwd_pkg::ST_OK)) |-> !active_ff)
      else $error("stream still active after error");

endmodule
